>>> hdl/wrp_pkg.sv
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared types and constants for the weighted random pick unit.
// ----------------------------------------------------------------------------
package wrp_pkg;

   localparam int ENTRIES     = 16;
   localparam int WEIGHT_BITS = 16;

   // Field widths of the channel and register beats
   localparam int INDEX_W = 4;
   localparam int FIELD_W = 16;
   localparam int VALUE_W = 32;
   localparam int RAND_W  = 31;
   localparam int CFG_W   = 5;

   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int TOTAL_W = WEIGHT_BITS + IDX_W;
   localparam int STEP_W  = $clog2(RAND_W);

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2);

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_DRAW  = 1'b1
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SUM  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   typedef struct packed {
      logic                   en;
      logic [IDX_W-1:0]       addr;
      logic [WEIGHT_BITS-1:0] weight;
      logic [VALUE_W-1:0]     value;
   } tbl_wr_type;

endpackage

>>> hdl/wrp_req_if.sv
// ----------------------------------------------------------------------------
// wrp_req_if
// Request channel: table writes and draw requests.
// ----------------------------------------------------------------------------
interface wrp_req_if import wrp_pkg::*; ();
   logic                valid;
   logic                ready;
   cmd_type             cmd;
   logic [INDEX_W-1:0]  entry_index;
   logic [FIELD_W-1:0]  weight;
   logic signed [VALUE_W-1:0] entry_value;
   logic [RAND_W-1:0]   random_word;

   modport source (output valid, cmd, entry_index, weight, entry_value, random_word,
                   input ready);
   modport sink   (input valid, cmd, entry_index, weight, entry_value, random_word,
                   output ready);
endinterface

>>> hdl/wrp_rsp_if.sv
// ----------------------------------------------------------------------------
// wrp_rsp_if
// Response channel: one beat per draw.
// ----------------------------------------------------------------------------
interface wrp_rsp_if import wrp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] picked_value;
   logic [INDEX_W-1:0]        picked_index;
   logic                      zero_total;

   modport source (output valid, picked_value, picked_index, zero_total, input ready);
   modport sink   (input valid, picked_value, picked_index, zero_total, output ready);
endinterface

>>> hdl/wrp_table.sv
// ----------------------------------------------------------------------------
// wrp_table
// Weight and value storage, one write port, one registered read port.
// ----------------------------------------------------------------------------
module wrp_table import wrp_pkg::*; (
   input  logic                   clock,
   input  tbl_wr_type             wr,
   input  logic [IDX_W-1:0]       rd_addr,
   output logic [WEIGHT_BITS-1:0] rd_weight,
   output logic [VALUE_W-1:0]     rd_value
);

   logic [WEIGHT_BITS-1:0] wt_mem [ENTRIES];
   logic [VALUE_W-1:0]     val_mem [ENTRIES];
   logic [WEIGHT_BITS-1:0] rd_weight_ff;
   logic [VALUE_W-1:0]     rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         wt_mem[wr.addr]  <= wr.weight;
         val_mem[wr.addr] <= wr.value;
      end
      rd_weight_ff <= wt_mem[rd_addr];
      rd_value_ff  <= val_mem[rd_addr];
   end

   assign rd_weight = rd_weight_ff;
   assign rd_value  = rd_value_ff;

endmodule

>>> hdl/wrp_mod_serial.sv
// ----------------------------------------------------------------------------
// wrp_mod_serial
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module wrp_mod_serial import wrp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [RAND_W-1:0]  dividend,
   input  logic [TOTAL_W-1:0] divisor,
   output logic               done,
   output logic [TOTAL_W-1:0] remainder
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [RAND_W-1:0]  dvd_ff, dvd_in;
   logic [TOTAL_W-1:0] dvs_ff, dvs_in;
   logic [TOTAL_W-1:0] rem_ff, rem_in;
   logic [TOTAL_W:0]   trial;
   logic               fits;

   // remainder stays below divisor, so trial < 2*divisor
   assign trial = {rem_ff, dvd_ff[RAND_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? TOTAL_W'(trial - {1'b0, dvs_ff}) : trial[TOTAL_W-1:0];
         dvd_in = {dvd_ff[RAND_W-2:0], 1'b0};
         cnt_in = STEP_W'(cnt_ff + 1'b1);
         if (cnt_ff == STEP_W'(RAND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> hdl/weighted_random_pick_unit.sv
// Write beat: table updated at the accepting edge, no response.
// Draw beat: sums the weights in use, then (unless the total is zero) runs the
// bit-serial remainder unit and scans running sums, then loads the response register.
// Reset (synchronous, active high) sets entries_in_use to 2 and empties the
// response register; table contents are undefined until written.
// ----------------------------------------------------------------------------
// weighted_random_pick_unit
// Weighted random selection by cumulative weight inversion.
// ----------------------------------------------------------------------------
module weighted_random_pick_unit import wrp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata,
   wrp_req_if.sink          req_if,
   wrp_rsp_if.source        rsp_if
);

   logic [CFG_W-1:0]   csr_ff;
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               dvld_ff, dvld_in;
   logic [IDX_W-1:0]   didx_ff, didx_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] run_ff, run_in;
   logic [TOTAL_W-1:0] r_ff, r_in;
   logic [RAND_W-1:0]  rnd_ff, rnd_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic [IDX_W-1:0]   res_index_ff, res_index_in;
   logic               res_zero_ff, res_zero_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic               rsp_zero_ff;

   logic [CNT_W-1:0]       n_act;
   logic                   accept;
   logic                   load_out;
   tbl_wr_type             tbl_wr;
   logic [IDX_W-1:0]       rd_addr;
   logic [WEIGHT_BITS-1:0] rd_weight;
   logic [VALUE_W-1:0]     rd_value;
   logic [TOTAL_W-1:0]     run_sum;
   logic                   hit;
   logic                   last_entry;
   logic                   div_start;
   logic                   div_done;
   logic [TOTAL_W-1:0]     div_rem;

   always_comb begin
      priority if (csr_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (32'(csr_ff) > 32'(ENTRIES)) begin
         n_act = CNT_W'(ENTRIES);
      end else begin
         n_act = CNT_W'(csr_ff);
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      tbl_wr.en     = accept && (req_if.cmd == CMD_WRITE) &&
                      (32'(req_if.entry_index) < 32'(ENTRIES));
      tbl_wr.addr   = IDX_W'(req_if.entry_index);
      tbl_wr.weight = WEIGHT_BITS'(req_if.weight);
      tbl_wr.value  = req_if.entry_value;
   end

   // idx_ff may reach n; the wrapped address is never consumed
   assign rd_addr = idx_ff[IDX_W-1:0];

   wrp_table u_table (
      .clock     (clock),
      .wr        (tbl_wr),
      .rd_addr   (rd_addr),
      .rd_weight (rd_weight),
      .rd_value  (rd_value)
   );

   wrp_mod_serial u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rnd_ff),
      .divisor   (total_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign run_sum    = TOTAL_W'(run_ff + TOTAL_W'(rd_weight));
   assign hit        = run_sum >= r_ff;
   assign last_entry = didx_ff == IDX_W'(n_act - 1'b1);
   assign load_out   = (state_ff == ST_DONE) && (!rsp_vld_ff || rsp_if.ready);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      dvld_in      = dvld_ff;
      didx_in      = didx_ff;
      total_in     = total_ff;
      run_in       = run_ff;
      r_in         = r_ff;
      rnd_in       = rnd_ff;
      res_value_in = res_value_ff;
      res_index_in = res_index_ff;
      res_zero_in  = res_zero_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_if.cmd == CMD_DRAW)) begin
               rnd_in   = req_if.random_word;
               idx_in   = '0;
               dvld_in  = 1'b0;
               total_in = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // read issued this cycle, data lands next cycle
            dvld_in = idx_ff != n_act;
            if (idx_ff != n_act) begin
               didx_in = idx_ff[IDX_W-1:0];
               idx_in  = CNT_W'(idx_ff + 1'b1);
            end
            if (dvld_ff) begin
               total_in = TOTAL_W'(total_ff + TOTAL_W'(rd_weight));
            end
            if ((idx_ff == n_act) && !dvld_ff) begin
               if (total_ff == '0) begin
                  res_value_in = '0;
                  res_index_in = '0;
                  res_zero_in  = 1'b1;
                  state_in     = ST_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               r_in     = TOTAL_W'(div_rem + 1'b1);
               idx_in   = '0;
               dvld_in  = 1'b0;
               run_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            dvld_in = idx_ff != n_act;
            if (idx_ff != n_act) begin
               didx_in = idx_ff[IDX_W-1:0];
               idx_in  = CNT_W'(idx_ff + 1'b1);
            end
            if (dvld_ff) begin
               run_in = run_sum;
               if (hit || last_entry) begin
                  res_value_in = rd_value;
                  res_index_in = didx_ff;
                  res_zero_in  = 1'b0;
                  dvld_in      = 1'b0;
                  state_in     = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_vld_in = load_out || (rsp_vld_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff     <= CFG_RESET;
         state_ff   <= ST_IDLE;
         dvld_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
         state_ff   <= state_in;
         dvld_ff    <= dvld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      didx_ff      <= didx_in;
      total_ff     <= total_in;
      run_ff       <= run_in;
      r_ff         <= r_in;
      rnd_ff       <= rnd_in;
      res_value_ff <= res_value_in;
      res_index_ff <= res_index_in;
      res_zero_ff  <= res_zero_in;
      if (load_out) begin
         rsp_value_ff <= res_value_ff;
         rsp_index_ff <= INDEX_W'(res_index_ff);
         rsp_zero_ff  <= res_zero_ff;
      end
   end

   assign rsp_if.valid        = rsp_vld_ff;
   assign rsp_if.picked_value = rsp_value_ff;
   assign rsp_if.picked_index = rsp_index_ff;
   assign rsp_if.zero_total   = rsp_zero_ff;

`ifndef SYNTHESIS
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("remainder done outside divide phase");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (total_ff != '0))
      else $error("divide started with zero total");

   a_target_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((r_ff != '0) && (r_ff <= total_ff)))
      else $error("scan target outside 1..total");

   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && dvld_ff) |-> (CNT_W'(didx_ff) < n_act))
      else $error("scan read beyond entries in use");

   a_load_once: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (state_ff == ST_IDLE) && rsp_vld_ff)
      else $error("response load did not complete the draw");
`endif

endmodule

>>> sim/wrp_checker.sv
// ----------------------------------------------------------------------------
// wrp_checker
// Scoreboard for the weighted random pick unit. Tracks the table and the entry
// count from the accepted beats, predicts each draw and compares responses.
// ----------------------------------------------------------------------------
module wrp_checker import wrp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata,
   wrp_req_if               req,
   wrp_rsp_if               rsp,
   output int               fail_count,
   output int               pending
);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        index;
      logic                      zero_total;
   } pick_type;

   logic [WEIGHT_BITS-1:0] weights [ENTRIES];
   logic [VALUE_W-1:0]     values  [ENTRIES];
   logic [CFG_W-1:0]       entry_count = CFG_RESET;
   pick_type               picks_due [$];
   int                     errors = 0;

   // Invert the cumulative weight over the entries in use.
   function automatic pick_type draw_pick(logic [RAND_W-1:0] word);
      int unsigned        n;
      int unsigned        sel;
      logic [TOTAL_W-1:0] total;
      logic [TOTAL_W-1:0] running;
      logic [31:0]        target;
      pick_type           p;
      n = (entry_count == 0) ? 1 :
          ((32'(entry_count) > ENTRIES) ? ENTRIES : 32'(entry_count));
      total = '0;
      for (int i = 0; i < n; i++) total += TOTAL_W'(weights[i]);
      p = '0;
      if (total == 0) begin
         p.zero_total = 1'b1;
         return p;
      end
      target = (32'(word) % 32'(total)) + 32'd1;
      running = '0;
      sel = n - 1;
      for (int i = 0; i < n; i++) begin
         running += TOTAL_W'(weights[i]);
         if (32'(running) >= target) begin
            sel = i;
            break;
         end
      end
      p.value = values[sel];
      p.index = sel[INDEX_W-1:0];
      return p;
   endfunction

   task automatic flag(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      errors++;
   endtask

   always @(posedge clock) begin
      pick_type want;
      if (reset) begin
         entry_count = CFG_RESET;
         picks_due.delete();
      end else begin
         if (csr_we) entry_count = csr_wdata;
         // response side first so a stray beat never pairs with a draw taken this edge
         if (rsp.valid && rsp.ready) begin
            if (picks_due.size() == 0) begin
               $display("%0t: response beat with no draw pending, expected none actual %h/%h/%b",
                        $time, rsp.picked_value, rsp.picked_index, rsp.zero_total);
               errors++;
            end else begin
               want = picks_due.pop_front();
               if (rsp.picked_value !== want.value)
                  flag("picked_value", want.value, rsp.picked_value);
               if (rsp.picked_index !== want.index)
                  flag("picked_index", 32'(want.index), 32'(rsp.picked_index));
               if (rsp.zero_total !== want.zero_total)
                  flag("zero_total", 32'(want.zero_total), 32'(rsp.zero_total));
            end
         end
         if (req.valid && req.ready) begin
            if (req.cmd == CMD_WRITE) begin
               weights[req.entry_index] = req.weight;
               values[req.entry_index]  = req.entry_value;
            end else begin
               picks_due.push_back(draw_pick(req.random_word));
            end
         end
      end
      fail_count <= errors;
      pending    <= picks_due.size();
   end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for weighted_random_pick_unit: directed corner beats, then random
// phases of table writes and draws under varying entry counts, with random
// source gaps and sink stalls. Checking is done by wrp_checker.
// ----------------------------------------------------------------------------
module tb_top;
   import wrp_pkg::*;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             csr_we    = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;
   int               fail_count;
   int               pending;
   bit               idle_on   = 1'b1;
   bit               stall_on  = 1'b1;
   int               n_writes  = 0;
   int               n_draws   = 0;
   int               n_cfg     = 0;

   wrp_req_if req_if ();
   wrp_rsp_if rsp_if ();

   weighted_random_pick_unit dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .rsp_if    (rsp_if)
   );

   wrp_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req        (req_if),
      .rsp        (rsp_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Sink side: random stall bursts.
   initial begin
      int unsigned hold;
      hold = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold != 0) begin
            hold--;
            rsp_if.ready <= 1'b0;
         end else if (stall_on && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(0, 2);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // One request beat; returns at the edge that accepted it, valid still high.
   task automatic send(cmd_type c, logic [INDEX_W-1:0] idx, logic [FIELD_W-1:0] w,
                       logic [VALUE_W-1:0] v, logic [RAND_W-1:0] rw);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.cmd         <= c;
      req_if.entry_index <= idx;
      req_if.weight      <= w;
      req_if.entry_value <= v;
      req_if.random_word <= rw;
      do @(posedge clock); while (!req_if.ready);
      if (c == CMD_WRITE) n_writes++;
      else n_draws++;
   endtask

   // Entry count change, only once the unit has drained.
   task automatic set_entry_count(logic [CFG_W-1:0] cnt);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= cnt;
      @(posedge clock);
      csr_we    <= 1'b0;
      n_cfg++;
   endtask

   initial begin
      logic [FIELD_W-1:0] w;
      logic [RAND_W-1:0]  rw;
      req_if.valid       = 1'b0;
      req_if.cmd         = CMD_WRITE;
      req_if.entry_index = '0;
      req_if.weight      = '0;
      req_if.entry_value = '0;
      req_if.random_word = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero total with both entries in use at weight zero, then the extremes
      send(CMD_WRITE, INDEX_W'(0), 16'h0000, 32'h7FFF_FFFF, '0);
      send(CMD_WRITE, INDEX_W'(1), 16'h0000, 32'h8000_0000, '0);
      send(CMD_DRAW,  INDEX_W'(0), 16'h0000, 32'h0000_0000, 31'h0000_0000);
      send(CMD_DRAW,  INDEX_W'(0), 16'h0000, 32'h0000_0000, 31'h7FFF_FFFF);
      send(CMD_WRITE, INDEX_W'(1), 16'hFFFF, 32'h8000_0000, 31'h7FFF_FFFF);
      send(CMD_DRAW,  INDEX_W'(0), 16'h0000, 32'h0000_0000, 31'h0000_0000);
      send(CMD_DRAW,  INDEX_W'(15), 16'hFFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      for (int i = 2; i < ENTRIES; i++)
         send(CMD_WRITE, INDEX_W'(i), (i == ENTRIES - 1) ? 16'hFFFF : 16'(i * 97),
              $urandom, RAND_W'($urandom));
      // count of zero acts as one entry; large counts saturate
      set_entry_count(CFG_W'(0));
      send(CMD_DRAW, INDEX_W'(0), 16'h0000, 32'h0000_0000, 31'h7FFF_FFFF);
      set_entry_count(CFG_W'(31));
      send(CMD_DRAW, INDEX_W'(0), 16'h0000, 32'h0000_0000, 31'h7FFF_FFFF);
      set_entry_count(CFG_W'(16));
      send(CMD_DRAW, INDEX_W'(0), 16'h0000, 32'h0000_0000, 31'h0000_0000);

      for (int phase = 0; phase < 31; phase++) begin
         idle_on  = (phase < 27) && ($urandom_range(0, 3) != 0);
         stall_on = (phase < 27) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 5))
            0:       set_entry_count(CFG_W'(0));
            1:       set_entry_count(CFG_W'(1));
            2:       set_entry_count(CFG_W'(16));
            3:       set_entry_count(CFG_W'($urandom_range(17, 31)));
            default: set_entry_count(CFG_W'($urandom_range(0, 31)));
         endcase
         repeat (50) begin
            if ($urandom_range(0, 99) < 40) begin
               case ($urandom_range(0, 7))
                  0:       w = 16'h0000;
                  1:       w = 16'hFFFF;
                  2:       w = FIELD_W'($urandom_range(1, 8));
                  default: w = FIELD_W'($urandom);
               endcase
               send(CMD_WRITE, INDEX_W'($urandom_range(0, 15)), w, $urandom,
                    RAND_W'($urandom));
            end else begin
               case ($urandom_range(0, 9))
                  0:       rw = 31'h0000_0000;
                  1:       rw = 31'h7FFF_FFFF;
                  default: rw = RAND_W'($urandom);
               endcase
               // address/weight/value are don't-care on a draw; drive noise there
               send(CMD_DRAW, INDEX_W'($urandom), FIELD_W'($urandom), $urandom, rw);
            end
         end
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("Covered %0d table writes and %0d draws over %0d entry-count settings,",
               n_writes, n_draws, n_cfg);
      $display("including zero total weight, count zero and saturated counts.");
      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> sim.f
hdl/wrp_pkg.sv
hdl/wrp_req_if.sv
hdl/wrp_rsp_if.sv
hdl/wrp_table.sv
hdl/wrp_mod_serial.sv
hdl/weighted_random_pick_unit.sv
sim/wrp_checker.sv
sim/tb_top.sv
